/* rtl/tcw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared widths, cell codes and the sequencer microprogram of the text
// console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int CHAR_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int CELL_W  = CHAR_W + ATTR_W;

   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;
   localparam logic [ATTR_W-1:0] RESET_COLOR  = 8'd7;

   // step counter codes
   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] PC_CLEAR    = 4'd0;
   localparam logic [PC_W-1:0] PC_IDLE     = 4'd1;
   localparam logic [PC_W-1:0] PC_DISPATCH = 4'd2;
   localparam logic [PC_W-1:0] PC_PUT      = 4'd3;
   localparam logic [PC_W-1:0] PC_WRCH     = 4'd4;
   localparam logic [PC_W-1:0] PC_LF       = 4'd5;
   localparam logic [PC_W-1:0] PC_COPY_RD  = 4'd6;
   localparam logic [PC_W-1:0] PC_COPY_WR  = 4'd7;
   localparam logic [PC_W-1:0] PC_FILL     = 4'd8;
   localparam logic [PC_W-1:0] PC_ROWINC   = 4'd9;
   localparam logic [PC_W-1:0] PC_EMIT     = 4'd10;

   // branch conditions
   localparam int COND_W = 4;
   localparam logic [COND_W-1:0] COND_ALWAYS    = 4'd0;
   localparam logic [COND_W-1:0] COND_ACCEPT    = 4'd1;
   localparam logic [COND_W-1:0] COND_IS_READ   = 4'd2;
   localparam logic [COND_W-1:0] COND_NEWLINE   = 4'd3;
   localparam logic [COND_W-1:0] COND_COL_WRAP  = 4'd4;
   localparam logic [COND_W-1:0] COND_ROW_LAST  = 4'd5;
   localparam logic [COND_W-1:0] COND_PTR_LAST  = 4'd6;
   localparam logic [COND_W-1:0] COND_COPY_LAST = 4'd7;
   localparam logic [COND_W-1:0] COND_RSP_FREE  = 4'd8;

   // write data select
   localparam int WD_W = 2;
   localparam logic [WD_W-1:0] WD_RESET_BLANK = 2'd0;
   localparam logic [WD_W-1:0] WD_CHAR        = 2'd1;
   localparam logic [WD_W-1:0] WD_COPY        = 2'd2;
   localparam logic [WD_W-1:0] WD_BLANK       = 2'd3;

   // read address select
   localparam logic RA_READ = 1'b0;
   localparam logic RA_COPY = 1'b1;

   typedef struct packed {
      logic [COND_W-1:0] cond;
      logic [PC_W-1:0]   tgt_true;
      logic [PC_W-1:0]   tgt_false;
      logic              rd_en;
      logic              rd_sel;
      logic              wr_en;
      logic [WD_W-1:0]   wr_sel;
      logic              ptr_inc;
      logic              ptr_clr;
      logic              col_inc;
      logic              col_clr;
      logic              row_inc;
      logic              scr_set;
      logic              scr_clr;
      logic              rsp_load;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = '0;
      unique case (pc)
         PC_CLEAR: begin
            w.wr_en     = 1'b1;
            w.wr_sel    = WD_RESET_BLANK;
            w.ptr_inc   = 1'b1;
            w.cond      = COND_PTR_LAST;
            w.tgt_true  = PC_IDLE;
            w.tgt_false = PC_CLEAR;
         end
         PC_IDLE: begin
            w.ptr_clr   = 1'b1;
            w.scr_clr   = 1'b1;
            w.cond      = COND_ACCEPT;
            w.tgt_true  = PC_DISPATCH;
            w.tgt_false = PC_IDLE;
         end
         PC_DISPATCH: begin
            w.rd_en     = 1'b1;
            w.rd_sel    = RA_READ;
            w.cond      = COND_IS_READ;
            w.tgt_true  = PC_EMIT;
            w.tgt_false = PC_PUT;
         end
         PC_PUT: begin
            w.cond      = COND_NEWLINE;
            w.tgt_true  = PC_LF;
            w.tgt_false = PC_WRCH;
         end
         PC_WRCH: begin
            w.wr_en     = 1'b1;
            w.wr_sel    = WD_CHAR;
            w.col_inc   = 1'b1;
            w.cond      = COND_COL_WRAP;
            w.tgt_true  = PC_LF;
            w.tgt_false = PC_EMIT;
         end
         PC_LF: begin
            w.col_clr   = 1'b1;
            w.cond      = COND_ROW_LAST;
            w.tgt_true  = PC_COPY_RD;
            w.tgt_false = PC_ROWINC;
         end
         PC_COPY_RD: begin
            w.scr_set   = 1'b1;
            w.rd_en     = 1'b1;
            w.rd_sel    = RA_COPY;
            w.cond      = COND_ALWAYS;
            w.tgt_true  = PC_COPY_WR;
            w.tgt_false = PC_COPY_WR;
         end
         PC_COPY_WR: begin
            w.wr_en     = 1'b1;
            w.wr_sel    = WD_COPY;
            w.ptr_inc   = 1'b1;
            w.cond      = COND_COPY_LAST;
            w.tgt_true  = PC_FILL;
            w.tgt_false = PC_COPY_RD;
         end
         PC_FILL: begin
            w.wr_en     = 1'b1;
            w.wr_sel    = WD_BLANK;
            w.ptr_inc   = 1'b1;
            w.cond      = COND_PTR_LAST;
            w.tgt_true  = PC_EMIT;
            w.tgt_false = PC_FILL;
         end
         PC_ROWINC: begin
            w.row_inc   = 1'b1;
            w.cond      = COND_ALWAYS;
            w.tgt_true  = PC_EMIT;
            w.tgt_false = PC_EMIT;
         end
         PC_EMIT: begin
            w.rsp_load  = 1'b1;
            w.cond      = COND_RSP_FREE;
            w.tgt_true  = PC_IDLE;
            w.tgt_false = PC_EMIT;
         end
         default: begin
            w.cond      = COND_ALWAYS;
            w.tgt_true  = PC_IDLE;
            w.tgt_false = PC_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

/* rtl/tcw_screen_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
   parameter int DEPTH = tcw_pkg::DEF_ROWS * tcw_pkg::DEF_COLUMNS
) (
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]        wr_addr,
   input  wire logic [tcw_pkg::CELL_W-1:0]      wr_data,
   input  wire logic                            rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]        rd_addr,
   output      logic [tcw_pkg::CELL_W-1:0]      rd_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] mem_ff [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/text_console_writer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine: puts characters at a cursor, wraps, scrolls,
// and reads back stored cells for display refresh.
// ----------------------------------------------------------------------------
// After reset the block sweeps the screen store to grey-on-black blanks, one
// cell per cycle; no item is taken during that sweep, though csr writes are.
// Each transfer then runs through a small microprogram: a read goes from
// dispatch to emit; an ordinary character goes through dispatch, put, the
// character write and emit; a newline without scroll through dispatch, put,
// the newline step, the row increment and emit. A scroll, caused by a
// newline or a wrap on the last row, moves every row but the first up by one
// and blanks the last row; each moved cell takes a read step and a write
// step, since the store has a single read and write port. A finished result
// waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic                           req_opcode,
   input  wire logic [tcw_pkg::CHAR_W-1:0]     req_char_code,
   input  wire logic [tcw_pkg::COL_W-1:0]      req_read_col,
   input  wire logic [tcw_pkg::ROW_W-1:0]      req_read_row,
   // response channel
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      logic [tcw_pkg::CELL_W-1:0]     rsp_cell_value,
   output      logic [tcw_pkg::COL_W-1:0]      rsp_cursor_col_out,
   output      logic [tcw_pkg::ROW_W-1:0]      rsp_cursor_row_out,
   output      logic                           rsp_scrolled,
   // attribute register write
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [tcw_pkg::ATTR_W-1:0]     csr_text_color
);
   import tcw_pkg::*;

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);

   localparam logic [ADDR_W-1:0] PTR_END   = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'((ROWS - 1) * COLUMNS - 1);
   localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLUMNS);
   localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
   localparam logic [COL_W:0]    COL_LIMIT = (COL_W + 1)'(COLUMNS);
   localparam logic [ROW_W:0]    ROW_LIMIT = (ROW_W + 1)'(ROWS);

   // ---- sequencer state ----
   logic [PC_W-1:0]   pc_ff, pc_in;
   ucode_type         uw;
   logic              cond_hit;

   // ---- datapath registers ----
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              scr_ff, scr_in;
   logic [ATTR_W-1:0] color_ff, color_in;

   // latched request fields
   logic              op_ff, op_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic [COL_W-1:0]  rcol_ff, rcol_in;
   logic [ROW_W-1:0]  rrow_ff, rrow_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_cell_ff, rsp_cell_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic              rsp_scr_ff, rsp_scr_in;

   logic              req_take;
   logic              rsp_free;
   logic              rsp_fire;
   logic              read_in_range;

   // ---- memory port signals ----
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [CELL_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [CELL_W-1:0] mem_rd_data;
   logic [ADDR_W-1:0] cursor_addr;
   logic [ADDR_W-1:0] read_addr;

   // ---- handshakes ----
   // take a request only while parked in the idle step
   assign req_stall = (pc_ff != PC_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_fire  = uw.rsp_load && rsp_free;

   // ---- control word fetch and branch ----
   assign uw = ucode_rom(pc_ff);

   always_comb begin
      unique case (uw.cond)
         COND_ALWAYS:    cond_hit = 1'b1;
         COND_ACCEPT:    cond_hit = req_take;
         COND_IS_READ:   cond_hit = op_ff;
         COND_NEWLINE:   cond_hit = (char_ff == NEWLINE_CODE);
         COND_COL_WRAP:  cond_hit = (col_ff == COL_LAST);
         COND_ROW_LAST:  cond_hit = (row_ff == ROW_LAST);
         COND_PTR_LAST:  cond_hit = (ptr_ff == PTR_END);
         COND_COPY_LAST: cond_hit = (ptr_ff == COPY_END);
         COND_RSP_FREE:  cond_hit = rsp_free;
         default:        cond_hit = 1'b1;
      endcase
   end

   assign pc_in = cond_hit ? uw.tgt_true : uw.tgt_false;

   // ---- addresses ----
   assign cursor_addr   = ADDR_W'(row_ff) * ROW_SPAN + ADDR_W'(col_ff);
   assign read_addr     = ADDR_W'(rrow_ff) * ROW_SPAN + ADDR_W'(rcol_ff);
   assign read_in_range = ({1'b0, rcol_ff} < COL_LIMIT) && ({1'b0, rrow_ff} < ROW_LIMIT);

   // ---- store access ----
   // drop reads of cells outside the screen; the result is zero anyway
   assign mem_rd_en   = uw.rd_en && ((uw.rd_sel == RA_COPY) || read_in_range);
   assign mem_rd_addr = (uw.rd_sel == RA_COPY) ? (ptr_ff + ROW_SPAN) : read_addr;

   assign mem_wr_en   = uw.wr_en;
   assign mem_wr_addr = (uw.wr_sel == WD_CHAR) ? cursor_addr : ptr_ff;

   always_comb begin
      case (uw.wr_sel)
         WD_RESET_BLANK: mem_wr_data = {RESET_COLOR, BLANK_CODE};
         WD_CHAR:        mem_wr_data = {color_ff, char_ff};
         WD_COPY:        mem_wr_data = mem_rd_data;
         WD_BLANK:       mem_wr_data = {color_ff, BLANK_CODE};
         default:        mem_wr_data = {color_ff, BLANK_CODE};
      endcase
   end

   tcw_screen_ram #(
      .DEPTH (CELLS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // ---- datapath next values ----
   always_comb begin
      // sweep pointer: clear in idle, advance through clear, copy and fill
      ptr_in = ptr_ff;
      if (uw.ptr_clr) begin
         ptr_in = '0;
      end else if (uw.ptr_inc) begin
         ptr_in = ptr_ff + ADDR_W'(1);
      end

      // cursor column: a wrap goes through the newline step, which clears it
      col_in = col_ff;
      if (uw.col_clr) begin
         col_in = '0;
      end else if (uw.col_inc) begin
         col_in = col_ff + COL_W'(1);
      end

      row_in = uw.row_inc ? (row_ff + ROW_W'(1)) : row_ff;

      scr_in = scr_ff;
      if (uw.scr_clr) begin
         scr_in = 1'b0;
      end else if (uw.scr_set) begin
         scr_in = 1'b1;
      end

      color_in = (csr_valid && csr_ready) ? csr_text_color : color_ff;

      // capture the request fields on the transfer
      op_in   = req_take ? req_opcode    : op_ff;
      char_in = req_take ? req_char_code : char_ff;
      rcol_in = req_take ? req_read_col  : rcol_ff;
      rrow_in = req_take ? req_read_row  : rrow_ff;

      // response register: load on emit, hold while stalled
      rsp_valid_in = rsp_fire ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_cell_in  = rsp_cell_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_scr_in   = rsp_scr_ff;
      if (rsp_fire) begin
         rsp_cell_in = (op_ff && read_in_range) ? mem_rd_data : '0;
         rsp_col_in  = col_ff;
         rsp_row_in  = row_ff;
         rsp_scr_in  = scr_ff;
      end
   end

   // ---- control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_CLEAR;
         ptr_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         scr_ff       <= 1'b0;
         color_ff     <= RESET_COLOR;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         ptr_ff       <= ptr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         scr_ff       <= scr_in;
         color_ff     <= color_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---- payload registers ----
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      char_ff     <= char_in;
      rcol_ff     <= rcol_in;
      rrow_ff     <= rrow_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_scr_ff  <= rsp_scr_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_value     = rsp_cell_ff;
   assign rsp_cursor_col_out = rsp_col_ff;
   assign rsp_cursor_row_out = rsp_row_ff;
   assign rsp_scrolled       = rsp_scr_ff;

   // ---- assertions ----
   // cursor stays on screen whenever the sequencer is parked
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == PC_IDLE) |-> ({1'b0, col_ff} < COL_LIMIT))
      else $error("cursor column off screen");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, row_ff} < ROW_LIMIT)
      else $error("cursor row off screen");

   // a scroll only ever happens with the cursor on the last row
   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      scr_ff |-> (row_ff == ROW_LAST))
      else $error("scroll flagged away from the last row");

   // every copy write follows its read
   a_copy_pair: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == PC_COPY_WR) |-> ($past(pc_ff) == PC_COPY_RD))
      else $error("copy write without preceding read");

   // the sequencer returns to idle right after a result is loaded
   a_emit_after_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |=> (pc_ff == PC_IDLE))
      else $error("sequencer did not return to idle after emit");

endmodule
`default_nettype wire
